@@ sv/ddfe_pkg.sv @@
// Types, sizes and helper functions for the decimal digit field extractor.
// No dependencies; every other file imports this package.
package ddfe_pkg;

   localparam int CodeWidth    = 31;
   localparam int FieldWidth   = 4;
   localparam int ValueWidth   = 30;
   localparam int DigitCount   = 10;
   localparam int BcdWidth     = 4 * DigitCount;
   localparam int MaxDigits    = 10;
   localparam int DabbleSteps  = 8;
   localparam int DabbleStages = (CodeWidth + DabbleSteps - 1) / DabbleSteps;
   localparam int CodeIdxWidth = $clog2(CodeWidth);
   localparam int HiDigits     = 5;
   localparam int LoDigits     = 4;
   localparam int HiWidth      = 17;
   localparam int CountWidth   = 5;

   typedef logic [CodeWidth-1:0]  code_type;
   typedef logic [FieldWidth-1:0] field_type;
   typedef logic [ValueWidth-1:0] value_type;
   typedef logic [BcdWidth-1:0]   bcd_type;
   typedef logic [HiWidth-1:0]    hi_type;
   typedef logic [CountWidth-1:0] count_type;

   // one shift-add-3 step of binary to BCD conversion
   function automatic bcd_type dabble_step(bcd_type b, logic code_bit);
      bcd_type r;
      r = b;
      for (int d = 0; d < DigitCount; d++) begin
         if (r[4*d +: 4] >= 4'd5) begin
            r[4*d +: 4] = r[4*d +: 4] + 4'd3;
         end
      end
      return {r[BcdWidth-2:0], code_bit};
   endfunction

endpackage

@@ sv/ddfe_req_if.sv @@
// Request channel: valid/ready handshake carrying code, field and skip counts.
// Depends on ddfe_pkg.
interface ddfe_req_if import ddfe_pkg::*; ();
   logic      valid;
   logic      ready;
   code_type  code;
   field_type field_digits;
   field_type skip_digits;

   modport source (output valid, code, field_digits, skip_digits, input ready);
   modport sink   (input valid, code, field_digits, skip_digits, output ready);
endinterface

@@ sv/ddfe_rsp_if.sv @@
// Response channel: valid/ready handshake carrying the extracted field value.
// Depends on ddfe_pkg.
interface ddfe_rsp_if import ddfe_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type field_value;
   logic      valid_res;

   modport source (output valid, field_value, valid_res, input ready);
   modport sink   (input valid, field_value, valid_res, output ready);
endinterface

@@ sv/decimal_digit_field_extract_core.sv @@
// Pipeline: a request passes 4 BCD conversion stages, digit select and two
// BCD-to-binary stages, each registered, before its response is valid.
// Throughput: one request per cycle; each stage holds only while the stage
// after it is full and stalled, so back-pressure costs no bubbles.
// Reset (synchronous, active high) clears all stage valid flags.
// Depends on ddfe_pkg, ddfe_req_if, ddfe_rsp_if.
module decimal_digit_field_extract_core import ddfe_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   ddfe_req_if.sink      req_bus,
   ddfe_rsp_if.source    rsp_bus
);

   logic      dd_valid_ff [DabbleStages];
   bcd_type   dd_bcd_ff   [DabbleStages];
   code_type  dd_code_ff  [DabbleStages];
   field_type dd_n_ff     [DabbleStages];
   field_type dd_k_ff     [DabbleStages];
   logic      dd_ready    [DabbleStages];

   logic      src_valid [DabbleStages];
   bcd_type   src_bcd   [DabbleStages];
   code_type  src_code  [DabbleStages];
   field_type src_n     [DabbleStages];
   field_type src_k     [DabbleStages];
   bcd_type   dd_bcd_in [DabbleStages];

   logic      sel_valid_ff;
   bcd_type   sel_bcd_ff;
   logic      sel_ok_ff;
   logic      sel_ready;
   bcd_type   sel_bcd_in;
   logic      sel_ok_in;

   logic      hor_valid_ff;
   hi_type    hor_hi_ff;
   logic [4*LoDigits-1:0] hor_lo_ff;
   logic      hor_ok_ff;
   logic      hor_ready;
   hi_type    hor_hi_in;

   logic      out_valid_ff;
   value_type out_value_ff;
   logic      out_ok_ff;
   logic      out_ready;
   value_type out_value_in;

   // ready chain, back to front
   always_comb begin
      out_ready = !out_valid_ff || rsp_bus.ready;
      hor_ready = !hor_valid_ff || out_ready;
      sel_ready = !sel_valid_ff || hor_ready;
      for (int s = DabbleStages - 1; s >= 0; s--) begin
         if (s == DabbleStages - 1) begin
            dd_ready[s] = !dd_valid_ff[s] || sel_ready;
         end else begin
            dd_ready[s] = !dd_valid_ff[s] || dd_ready[s+1];
         end
      end
   end

   assign req_bus.ready = dd_ready[0];

   // binary to BCD, DabbleSteps code bits per stage
   always_comb begin
      src_valid[0] = req_bus.valid;
      src_bcd[0]   = '0;
      src_code[0]  = req_bus.code;
      src_n[0]     = req_bus.field_digits;
      src_k[0]     = req_bus.skip_digits;
      for (int s = 1; s < DabbleStages; s++) begin
         src_valid[s] = dd_valid_ff[s-1];
         src_bcd[s]   = dd_bcd_ff[s-1];
         src_code[s]  = dd_code_ff[s-1];
         src_n[s]     = dd_n_ff[s-1];
         src_k[s]     = dd_k_ff[s-1];
      end
   end

   always_comb begin
      bcd_type b;
      int      idx;
      for (int s = 0; s < DabbleStages; s++) begin
         b = src_bcd[s];
         for (int j = 0; j < DabbleSteps; j++) begin
            idx = CodeWidth - 1 - s * DabbleSteps - j;
            if (idx >= 0) begin
               b = dabble_step(b, src_code[s][idx[CodeIdxWidth-1:0]]);
            end
         end
         dd_bcd_in[s] = b;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DabbleStages; s++) begin
         if (reset) begin
            dd_valid_ff[s] <= 1'b0;
         end else if (dd_ready[s]) begin
            dd_valid_ff[s] <= src_valid[s];
         end
         if (dd_ready[s]) begin
            dd_bcd_ff[s]  <= dd_bcd_in[s];
            dd_code_ff[s] <= src_code[s];
            dd_n_ff[s]    <= src_n[s];
            dd_k_ff[s]    <= src_k[s];
         end
      end
   end

   // count digits, check request, select field digits
   always_comb begin
      count_type m;
      field_type n;
      field_type k;
      bcd_type   b;
      bcd_type   shifted;
      bcd_type   mask;
      b = dd_bcd_ff[DabbleStages-1];
      n = dd_n_ff[DabbleStages-1];
      k = dd_k_ff[DabbleStages-1];
      m = count_type'(1);
      for (int d = 0; d < DigitCount; d++) begin
         if (b[4*d +: 4] != 4'd0) begin
            m = count_type'(d + 1);
         end
      end
      if (m > count_type'(MaxDigits)) begin
         m = count_type'(MaxDigits);
      end
      sel_ok_in = (n != '0) && (count_type'(n) < m)
                  && ((count_type'(n) + count_type'(k)) <= m);
      shifted = b >> {k, 2'b00};
      mask    = ~({BcdWidth{1'b1}} << {n, 2'b00});
      sel_bcd_in = sel_ok_in ? (shifted & mask) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
      end else if (sel_ready) begin
         sel_valid_ff <= dd_valid_ff[DabbleStages-1];
      end
      if (sel_ready) begin
         sel_bcd_ff <= sel_bcd_in;
         sel_ok_ff  <= sel_ok_in;
      end
   end

   // BCD to binary, upper digits
   always_comb begin
      hi_type acc;
      acc = '0;
      for (int d = LoDigits + HiDigits - 1; d >= LoDigits; d--) begin
         acc = hi_type'(acc * hi_type'(10)) + hi_type'(sel_bcd_ff[4*d +: 4]);
      end
      hor_hi_in = acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hor_valid_ff <= 1'b0;
      end else if (hor_ready) begin
         hor_valid_ff <= sel_valid_ff;
      end
      if (hor_ready) begin
         hor_hi_ff <= hor_hi_in;
         hor_lo_ff <= sel_bcd_ff[4*LoDigits-1:0];
         hor_ok_ff <= sel_ok_ff;
      end
   end

   // BCD to binary, lower digits
   always_comb begin
      value_type acc;
      acc = value_type'(hor_hi_ff);
      for (int d = LoDigits - 1; d >= 0; d--) begin
         acc = value_type'(acc * value_type'(10)) + value_type'(hor_lo_ff[4*d +: 4]);
      end
      out_value_in = acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= hor_valid_ff;
      end
      if (out_ready) begin
         out_value_ff <= out_value_in;
         out_ok_ff    <= hor_ok_ff;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.field_value = out_value_ff;
   assign rsp_bus.valid_res   = out_ok_ff;

endmodule
